// ===== sv/bq_pkg.sv =====
// ----------------------------------------------------------------------------
// bq_pkg
// Shared types and constants for the biquad low-pass filter: coefficient
// format, register indexes and the coefficient set bundle.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package bq_pkg;

  // Coefficient format: signed Q2.22
  localparam int COEF_W    = 24;
  localparam int COEF_FRAC = 22;

  // Configuration register index width (covers indexes past the last register)
  localparam int CFG_IDX_W = 3;

  // Register indexes
  typedef enum logic [CFG_IDX_W-1:0] {
    REG_A0 = 3'd0,
    REG_A1 = 3'd1,
    REG_A2 = 3'd2,
    REG_B1 = 3'd3,
    REG_B2 = 3'd4
  } coef_idx_t;

  // Full coefficient set as seen by the datapath
  typedef struct packed {
    logic signed [COEF_W-1:0] a0;
    logic signed [COEF_W-1:0] a1;
    logic signed [COEF_W-1:0] a2;
    logic signed [COEF_W-1:0] b1;
    logic signed [COEF_W-1:0] b2;
  } coef_set_t;

endpackage

// ===== sv/bq_ifs.sv =====
// ----------------------------------------------------------------------------
// bq_ifs
// Valid/ready channels of the biquad filter: sample input, filtered result
// output and coefficient register writes.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

// Input sample channel
interface bq_sample_if #(
  parameter int SAMPLE_BITS = 24
);
  logic                          valid;
  logic                          ready;
  logic signed [SAMPLE_BITS-1:0] sample_in;
  logic                          channel_in;
  logic                          end_of_block_in;

  modport source (output valid, sample_in, channel_in, end_of_block_in, input ready);
  modport sink   (input valid, sample_in, channel_in, end_of_block_in, output ready);
endinterface

// Filtered result channel
interface bq_result_if #(
  parameter int SAMPLE_BITS = 24
);
  logic                          valid;
  logic                          ready;
  logic signed [SAMPLE_BITS-1:0] sample_out;
  logic                          channel_out;
  logic                          end_of_block_out;
  logic                          saturated;

  modport source (output valid, sample_out, channel_out, end_of_block_out, saturated,
                  input ready);
  modport sink   (input valid, sample_out, channel_out, end_of_block_out, saturated,
                  output ready);
endinterface

// Coefficient register write channel
interface bq_cfg_if;
  import bq_pkg::*;
  logic                 valid;
  logic                 ready;
  logic [CFG_IDX_W-1:0] index;
  logic [COEF_W-1:0]    data;

  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface

// ===== sv/bq_coef_regs.sv =====
// ----------------------------------------------------------------------------
// bq_coef_regs
// Coefficient register file. Writes to indexes past the last register are
// dropped; the port is always ready.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module bq_coef_regs
  import bq_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  bq_cfg_if.sink      cfg,
  output coef_set_t   coefs
);

  coef_set_t coefs_q;

  assign cfg.ready = 1'b1;
  assign coefs     = coefs_q;

  // Register write decode
  always_ff @(posedge clk) begin
    if (rst) begin
      coefs_q <= '0;
    end else if (cfg.valid) begin
      case (cfg.index)
        REG_A0: coefs_q.a0 <= cfg.data;
        REG_A1: coefs_q.a1 <= cfg.data;
        REG_A2: coefs_q.a2 <= cfg.data;
        REG_B1: coefs_q.b1 <= cfg.data;
        REG_B2: coefs_q.b2 <= cfg.data;
        default: ;
      endcase
    end
  end

endmodule

// ===== sv/bq_history.sv =====
// ----------------------------------------------------------------------------
// bq_history
// Per-channel delay lines: two past inputs and two past outputs for each
// channel. Read at the current channel, shifted on a write.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module bq_history #(
  parameter  int CHANNELS    = 2,
  parameter  int SAMPLE_BITS = 24,
  localparam int IDX_W       = (CHANNELS > 1) ? $clog2(CHANNELS) : 1
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic [IDX_W-1:0]              idx,
  input  logic                          wr_en,
  input  logic signed [SAMPLE_BITS-1:0] x_new,
  input  logic signed [SAMPLE_BITS-1:0] y_new,
  output logic signed [SAMPLE_BITS-1:0] rd_x1,
  output logic signed [SAMPLE_BITS-1:0] rd_x2,
  output logic signed [SAMPLE_BITS-1:0] rd_y1,
  output logic signed [SAMPLE_BITS-1:0] rd_y2
);

  logic signed [SAMPLE_BITS-1:0] x1_q [CHANNELS];
  logic signed [SAMPLE_BITS-1:0] x2_q [CHANNELS];
  logic signed [SAMPLE_BITS-1:0] y1_q [CHANNELS];
  logic signed [SAMPLE_BITS-1:0] y2_q [CHANNELS];

  // Read of the addressed channel
  assign rd_x1 = x1_q[idx];
  assign rd_x2 = x2_q[idx];
  assign rd_y1 = y1_q[idx];
  assign rd_y2 = y2_q[idx];

  // Shift the addressed channel's history
  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < CHANNELS; i++) begin
        x1_q[i] <= '0;
        x2_q[i] <= '0;
        y1_q[i] <= '0;
        y2_q[i] <= '0;
      end
    end else if (wr_en) begin
      x2_q[idx] <= x1_q[idx];
      x1_q[idx] <= x_new;
      y2_q[idx] <= y1_q[idx];
      y1_q[idx] <= y_new;
    end
  end

`ifndef SYNTHESIS
  // A write shifts the addressed channel: new output lands in y1, old x1 in x2
  a_hist_shift: assert property (@(posedge clk) disable iff (rst)
    wr_en |=> (y1_q[$past(idx)] == $past(y_new)) && (x2_q[$past(idx)] == $past(rd_x1)))
    else $error("history shift mismatch");
`endif

endmodule

// ===== sv/bq_arith.sv =====
// ----------------------------------------------------------------------------
// bq_arith
// Direct form I sum of products: five parallel multiplies, exact sum,
// round half up at the Q2.22 point, saturate to the sample width.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module bq_arith
  import bq_pkg::*;
#(
  parameter int SAMPLE_BITS = 24
) (
  input  coef_set_t                     coefs,
  input  logic signed [SAMPLE_BITS-1:0] x,
  input  logic signed [SAMPLE_BITS-1:0] x1,
  input  logic signed [SAMPLE_BITS-1:0] x2,
  input  logic signed [SAMPLE_BITS-1:0] y1,
  input  logic signed [SAMPLE_BITS-1:0] y2,
  output logic signed [SAMPLE_BITS-1:0] y,
  output logic                          sat
);

  localparam int PROD_W = COEF_W + SAMPLE_BITS;
  localparam int ACC_W  = PROD_W + 3;
  localparam int RND_W  = ACC_W - COEF_FRAC;
  localparam logic signed [ACC_W-1:0]       RND_ADD = ACC_W'(1 << (COEF_FRAC - 1));
  localparam logic signed [SAMPLE_BITS-1:0] SMAX    = {1'b0, {(SAMPLE_BITS-1){1'b1}}};
  localparam logic signed [SAMPLE_BITS-1:0] SMIN    = {1'b1, {(SAMPLE_BITS-1){1'b0}}};

  logic signed [PROD_W-1:0]    p0, p1, p2, p3, p4;
  logic signed [ACC_W-1:0]     acc;
  logic signed [RND_W-1:0]     rnd;
  logic [RND_W-SAMPLE_BITS:0]  hi;
  logic                        in_range;

  // Products
  assign p0 = coefs.a0 * x;
  assign p1 = coefs.a1 * x1;
  assign p2 = coefs.a2 * x2;
  assign p3 = coefs.b1 * y1;
  assign p4 = coefs.b2 * y2;

  // Exact sum with rounding offset folded in
  assign acc = ACC_W'(p0) + ACC_W'(p1) + ACC_W'(p2) - ACC_W'(p3) - ACC_W'(p4) + RND_ADD;

  // Floor at the binary point, then clip
  assign rnd      = acc[ACC_W-1:COEF_FRAC];
  assign hi       = rnd[RND_W-1:SAMPLE_BITS-1];
  assign in_range = (&hi) | ~(|hi);
  assign sat      = ~in_range;

  always_comb begin
    if (in_range) begin
      y = rnd[SAMPLE_BITS-1:0];
    end else if (rnd[RND_W-1]) begin
      y = SMIN;
    end else begin
      y = SMAX;
    end
  end

endmodule

// ===== sv/biquad_lowpass_filter.sv =====
// ----------------------------------------------------------------------------
// biquad_lowpass_filter
// Multi-channel second-order IIR low-pass section, direct form I, Q2.22
// coefficients, rounded and saturated output.
// Flow: a word accepted into the input register moves on to the result register
//   once that register is free, and is then presented on the result channel.
// Throughput: one word per cycle while the result channel is not stalled; the
//   per-channel feedback through the five multipliers and the adder is combinational.
// Reset: clears coefficients, all channel histories and both pipeline stages.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module biquad_lowpass_filter
  import bq_pkg::*;
#(
  parameter int CHANNELS    = 2,
  parameter int SAMPLE_BITS = 24
) (
  input  logic           clk,
  input  logic           rst,
  bq_sample_if.sink      sample_chan,
  bq_result_if.source    result_chan,
  bq_cfg_if.sink         cfg_chan
);

  localparam int IDX_W = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
  localparam logic signed [SAMPLE_BITS-1:0] SMAX = {1'b0, {(SAMPLE_BITS-1){1'b1}}};
  localparam logic signed [SAMPLE_BITS-1:0] SMIN = {1'b1, {(SAMPLE_BITS-1){1'b0}}};

  coef_set_t                     coefs;

  // Input stage
  logic                          s1_valid;
  logic signed [SAMPLE_BITS-1:0] s1_sample;
  logic                          s1_channel;
  logic                          s1_eob;

  // Result stage
  logic                          res_valid;
  logic signed [SAMPLE_BITS-1:0] res_sample;
  logic                          res_channel;
  logic                          res_eob;
  logic                          res_sat;

  logic                          out_free;
  logic                          s1_adv;
  logic                          in_ready;
  logic [IDX_W-1:0]              chan_idx;
  logic signed [SAMPLE_BITS-1:0] h_x1, h_x2, h_y1, h_y2;
  logic signed [SAMPLE_BITS-1:0] y_calc;
  logic                          sat_calc;

  // Coefficient registers
  bq_coef_regs u_coef_regs (
    .clk   (clk),
    .rst   (rst),
    .cfg   (cfg_chan),
    .coefs (coefs)
  );

  // Handshake: the result register frees when empty or being taken
  assign out_free          = ~res_valid | result_chan.ready;
  assign s1_adv            = s1_valid & out_free;
  assign in_ready          = ~s1_valid | s1_adv;
  assign sample_chan.ready = in_ready;

  // Tags past the last channel fold onto the last one
  assign chan_idx = (CHANNELS > 1) ? IDX_W'(s1_channel) : '0;

  bq_history #(
    .CHANNELS    (CHANNELS),
    .SAMPLE_BITS (SAMPLE_BITS)
  ) u_history (
    .clk   (clk),
    .rst   (rst),
    .idx   (chan_idx),
    .wr_en (s1_adv),
    .x_new (s1_sample),
    .y_new (y_calc),
    .rd_x1 (h_x1),
    .rd_x2 (h_x2),
    .rd_y1 (h_y1),
    .rd_y2 (h_y2)
  );

  bq_arith #(
    .SAMPLE_BITS (SAMPLE_BITS)
  ) u_arith (
    .coefs (coefs),
    .x     (s1_sample),
    .x1    (h_x1),
    .x2    (h_x2),
    .y1    (h_y1),
    .y2    (h_y2),
    .y     (y_calc),
    .sat   (sat_calc)
  );

  // Pipeline valid bits
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid  <= 1'b0;
      res_valid <= 1'b0;
    end else begin
      if (in_ready) begin
        s1_valid <= sample_chan.valid;
      end
      if (out_free) begin
        res_valid <= s1_valid;
      end
    end
  end

  // Pipeline payload
  always_ff @(posedge clk) begin
    if (sample_chan.valid && in_ready) begin
      s1_sample  <= sample_chan.sample_in;
      s1_channel <= sample_chan.channel_in;
      s1_eob     <= sample_chan.end_of_block_in;
    end
    if (s1_adv) begin
      res_sample  <= y_calc;
      res_channel <= s1_channel;
      res_eob     <= s1_eob;
      res_sat     <= sat_calc;
    end
  end

  assign result_chan.valid            = res_valid;
  assign result_chan.sample_out       = res_sample;
  assign result_chan.channel_out      = res_channel;
  assign result_chan.end_of_block_out = res_eob;
  assign result_chan.saturated        = res_sat;

`ifndef SYNTHESIS
  // A word leaving the input stage always lands in the result register
  a_adv_fills: assert property (@(posedge clk) disable iff (rst)
    s1_adv |=> res_valid)
    else $error("advanced word lost");

  // A clipped result sits at one of the range limits
  a_sat_limit: assert property (@(posedge clk) disable iff (rst)
    (res_valid && res_sat) |-> ((res_sample == SMAX) || (res_sample == SMIN)))
    else $error("saturated flag without limit value");

  // Reset empties both stages
  a_rst_empty: assert property (@(posedge clk)
    rst |=> (!s1_valid && !res_valid))
    else $error("pipeline not empty after reset");
`endif

endmodule
